// ===== src/cmc_pkg.sv =====
`default_nettype none
package cmc_pkg;

  localparam int NUM_SNP_REGS = 6;

  localparam logic [7:0] CHAR_STAR     = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_N        = 8'h4E;  // 'N'
  localparam logic [7:0] CHAR_LOW_A    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOW_Z    = 8'h7A;  // 'z'
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  localparam logic [2:0] REG_SUBST_LIMIT = 3'd0;
  localparam logic [2:0] REG_SNP_COUNT   = 3'd1;
  localparam logic [2:0] REG_SNP_POS_A   = 3'd2;
  localparam logic [2:0] REG_SNP_POS_B   = 3'd3;
  localparam logic [2:0] REG_SNP_POS_C   = 3'd4;
  localparam logic [2:0] REG_SNP_POS_D   = 3'd5;
  localparam logic [2:0] REG_SNP_POS_E   = 3'd6;
  localparam logic [2:0] REG_SNP_POS_F   = 3'd7;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_SUBST = 2'd1,
    VERDICT_SNP   = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] frag_char;
    logic [7:0] read_char;
    logic [7:0] start_pos;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       mappable;
    logic [1:0] verdict;
    logic [7:0] subst_seen;
  } out_item_t;

  typedef struct packed {
    logic [7:0]                         subst_limit;
    logic [2:0]                         snp_count;
    logic [NUM_SNP_REGS-1:0][7:0]       snp_pos;
  } cfg_t;

  function automatic logic is_wild(input logic [7:0] c);
    return (c == CHAR_STAR) || (c == CHAR_QUESTION) || (c == CHAR_N);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z)) ? (c - CASE_OFFSET) : c;
  endfunction

endpackage
`default_nettype wire

// ===== src/cmc_cfg.sv =====
`default_nettype none
module cmc_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [7:0]    cfg_wdata,
  output cmc_pkg::cfg_t      cfg
);
  import cmc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_SUBST_LIMIT: cfg_nxt.subst_limit = cfg_wdata;
        REG_SNP_COUNT:   cfg_nxt.snp_count   = cfg_wdata[2:0];
        REG_SNP_POS_A:   cfg_nxt.snp_pos[0]  = cfg_wdata;
        REG_SNP_POS_B:   cfg_nxt.snp_pos[1]  = cfg_wdata;
        REG_SNP_POS_C:   cfg_nxt.snp_pos[2]  = cfg_wdata;
        REG_SNP_POS_D:   cfg_nxt.snp_pos[3]  = cfg_wdata;
        REG_SNP_POS_E:   cfg_nxt.snp_pos[4]  = cfg_wdata;
        REG_SNP_POS_F:   cfg_nxt.snp_pos[5]  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.subst_limit <= 8'd1;
      cfg_r.snp_count   <= 3'd0;
      cfg_r.snp_pos     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/cmc_core.sv =====
`default_nettype none
module cmc_core #(
  parameter logic [7:0] POS_CEIL = 8'd255,
  parameter logic [2:0] SLOT_CAP = 3'd6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmc_pkg::cfg_t      cfg,
  input  wire logic               step_en,
  input  wire cmc_pkg::in_item_t  item,
  output cmc_pkg::out_item_t      res
);
  import cmc_pkg::*;

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic       rej_r, rej_nxt;
  logic [1:0] cause_r, cause_nxt;

  logic [2:0] n_valid;
  logic [7:0] pos0, cnt0;
  logic [2:0] slot0;
  logic       rej0;
  logic [1:0] cause0;
  logic       mismatch;

  function automatic logic [7:0] snp_at(input cfg_t c, input logic [2:0] s);
    logic [7:0] v;
    v = 8'd0;
    case (s)
      3'd0: v = c.snp_pos[0];
      3'd1: v = c.snp_pos[1];
      3'd2: v = c.snp_pos[2];
      3'd3: v = c.snp_pos[3];
      3'd4: v = c.snp_pos[4];
      3'd5: v = c.snp_pos[5];
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  assign n_valid = (cfg.snp_count > SLOT_CAP) ? SLOT_CAP : cfg.snp_count;

  always_comb begin
    // a first request restarts the alignment before the pair is checked
    pos0   = item.first ? ((item.start_pos > POS_CEIL) ? POS_CEIL : item.start_pos) : pos_r;
    cnt0   = item.first ? 8'd0 : cnt_r;
    slot0  = item.first ? 3'd0 : slot_r;
    rej0   = item.first ? 1'b0 : rej_r;
    cause0 = item.first ? VERDICT_OK : cause_r;

    pos_nxt   = pos0;
    cnt_nxt   = cnt0;
    slot_nxt  = slot0;
    rej_nxt   = rej0;
    cause_nxt = cause0;
    mismatch  = (item.frag_char != to_upper(item.read_char)) && !is_wild(item.frag_char);

    if (!rej0) begin
      // advance at most one slot per request
      if ((slot0 < n_valid) && (pos0 > snp_at(cfg, slot0))) begin
        slot_nxt = slot0 + 3'd1;
      end
      if (mismatch) begin
        if (cnt0 != 8'hFF) begin
          cnt_nxt = cnt0 + 8'd1;
        end
        if (cnt_nxt > cfg.subst_limit) begin
          rej_nxt   = 1'b1;
          cause_nxt = VERDICT_SUBST;
        end else if ((slot_nxt < n_valid) && (pos0 == snp_at(cfg, slot_nxt))) begin
          rej_nxt   = 1'b1;
          cause_nxt = VERDICT_SNP;
        end
      end
      if (pos0 < POS_CEIL) begin
        pos_nxt = pos0 + 8'd1;
      end
    end

    res.mappable   = !rej_nxt;
    res.verdict    = cause_nxt;
    res.subst_seen = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 8'd0;
      cnt_r   <= 8'd0;
      slot_r  <= 3'd0;
      rej_r   <= 1'b0;
      cause_r <= VERDICT_OK;
    end else if (step_en) begin
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
      rej_r   <= rej_nxt;
      cause_r <= cause_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/constrained_mismatch_checker.sv =====
// Result path: each pair is taken into the input register; a last pair's result is then held in the result register.
// Throughput: one character pair per cycle unless a last pair stalls on the result side; the position,
// counter and SNP pointer update for a pair is combinational between the two registers.
// A stalled result holds the input side only while the pair in the input register is last.
// Reset (synchronous, rst_n low): pipeline empty, alignment state cleared,
// subst_limit = 1, snp_count = 0, SNP positions = 0.
`default_nettype none
module constrained_mismatch_checker #(
  parameter int MAX_FRAG_LEN = 256,
  parameter int SNP_SLOTS    = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cmc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cmc_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [7:0]         cfg_wdata
);
  import cmc_pkg::*;

  localparam int         CEIL_INT = (MAX_FRAG_LEN - 1 > 255) ? 255 : MAX_FRAG_LEN - 1;
  localparam logic [7:0] POS_CEIL = 8'(CEIL_INT);
  localparam int         CAP_INT  = (SNP_SLOTS > NUM_SNP_REGS) ? NUM_SNP_REGS : SNP_SLOTS;
  localparam logic [2:0] SLOT_CAP = 3'(CAP_INT);

  cfg_t       cfg;
  in_item_t   item_r;
  logic       item_vld_r;
  out_item_t  res;
  out_item_t  out_r;
  logic       out_vld_r;
  logic       advance;

  cmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cmc_core #(
    .POS_CEIL (POS_CEIL),
    .SLOT_CAP (SLOT_CAP)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (advance),
    .item    (item_r),
    .res     (res)
  );

  // a pair without last never needs the result register
  assign advance  = item_vld_r && (!item_r.last || !out_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && item_r.last) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_r.last) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
